FILE: sv/ifd_pkg.sv
`default_nettype none

package ifd_pkg;

    localparam int CHANNELS_DEF = 14;
    localparam int CENTER_DEF   = 1500;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // frame store holds byte pairs: pair k is bytes 2k and 2k+1
    localparam int FRAME_PAIRS = 16;
    localparam int PAIR_AW     = 4;
    localparam int POS_W       = 5;
    localparam int CHAN_W      = 4;

    localparam logic [15:0]      SUM_INIT = 16'hFFFF;
    localparam logic [POS_W-1:0] SUM_LEN  = 5'd30;
    localparam logic [POS_W-1:0] LAST_POS = 5'd31;
    localparam logic [7:0]       CNT_MAX  = 8'hFF;

    typedef enum logic [1:0] {
        LINK_NOSYNC = 2'd0,
        LINK_ACQ    = 2'd1,
        LINK_READY  = 2'd2,
        LINK_FAIL   = 2'd3
    } t_link;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_ABORT  = 3'd1,
        EV_BADSUM = 3'd2,
        EV_HELD   = 3'd3,
        EV_PUB    = 3'd4
    } t_event;

    typedef enum logic [2:0] {
        REG_START   = 3'd0,
        REG_COMMAND = 3'd1,
        REG_ACQUIRE = 3'd2,
        REG_SKIP    = 3'd3,
        REG_LOW     = 3'd4,
        REG_HIGH    = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_READ,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  command_byte;
        logic [7:0]  acquire_frames;
        logic [7:0]  frames_to_skip;
        logic [15:0] pulse_low_limit;
        logic [15:0] pulse_high_limit;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic step;
        logic read;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic step_pub;
        logic out_free;
        logic last_chan;
    } t_stat;

endpackage

`default_nettype wire

FILE: sv/ifd_in_if.sv
`default_nettype none

interface ifd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       rx_error;
    logic       gap_seen;

    modport source (output valid, output data_byte, output rx_error, output gap_seen,
                    input ready);
    modport sink (input valid, input data_byte, input rx_error, input gap_seen,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/ifd_out_if.sv
`default_nettype none

interface ifd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  link_state;
    logic [2:0]  frame_event;
    logic [3:0]  channel_index;
    logic [15:0] channel_value;
    logic        last_result;

    modport source (output valid, output link_state, output frame_event,
                    output channel_index, output channel_value, output last_result,
                    input ready);
    modport sink (input valid, input link_state, input frame_event,
                  input channel_index, input channel_value, input last_result,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/ifd_ram.sv
`default_nettype none

module ifd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: sv/ifd_ctrl.sv
`default_nettype none

module ifd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire ifd_pkg::t_stat i_stat,
    output ifd_pkg::t_cmd      o_cmd
);

    import ifd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_STEP;
                end
            end
            ST_STEP: begin
                // a non-publishing step writes its result straight to the output register
                if (i_stat.out_free) begin
                    o_cmd.step = 1'b1;
                    n_state    = i_stat.step_pub ? ST_READ : ST_IDLE;
                end
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_stat.last_chan ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/ifd_datapath.sv
`default_nettype none

module ifd_datapath #(
    parameter int CHANNELS     = ifd_pkg::CHANNELS_DEF,
    parameter int CENTER_VALUE = ifd_pkg::CENTER_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ifd_pkg::t_cmd i_cmd,
    output ifd_pkg::t_stat     o_stat,
    input  wire ifd_pkg::t_cfg i_cfg,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_rx_error,
    input  wire logic          i_gap_seen,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output logic [1:0]         o_link_state,
    output logic [2:0]         o_frame_event,
    output logic [3:0]         o_channel_index,
    output logic [15:0]        o_channel_value,
    output logic               o_last_result
);

    import ifd_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(CHANNELS - 1);
    localparam logic [15:0]       CENTER    = 16'(CENTER_VALUE);

    // captured transaction
    logic [7:0] r_byte;
    logic       r_err;
    logic       r_gap;

    // frame tracking
    logic [POS_W-1:0] r_pos,  n_pos;
    t_link            r_link, n_link;
    logic [7:0]       r_acq,  n_acq;
    logic [7:0]       r_skip, n_skip;
    logic [15:0]      r_sum,  n_sum;
    logic [7:0]       r_low,  n_low;
    t_event           step_ev;
    logic             ram_we;

    logic [7:0]  acq_inc;
    logic [7:0]  skip_inc;
    logic [15:0] sum_sub;

    // publish loop
    logic [CHAN_W-1:0] r_chan;
    logic [15:0]       r_store [CHANNELS];
    logic [15:0]       pair_data;
    logic              in_range;
    logic [15:0]       new_value;

    logic        r_out_valid;
    logic [1:0]  r_out_link;
    logic [2:0]  r_out_ev;
    logic [3:0]  r_out_idx;
    logic [15:0] r_out_val;
    logic        r_out_last;

    assign acq_inc  = (r_acq == CNT_MAX) ? r_acq : r_acq + 8'd1;
    assign skip_inc = (r_skip == CNT_MAX) ? r_skip : r_skip + 8'd1;
    assign sum_sub  = r_sum - {8'd0, r_byte};

    always_comb begin
        n_pos   = r_pos;
        n_link  = r_link;
        n_acq   = r_acq;
        n_skip  = r_skip;
        n_sum   = r_sum;
        n_low   = r_low;
        step_ev = EV_NONE;
        ram_we  = 1'b0;
        if (r_err) begin
            n_pos   = '0;
            n_link  = LINK_FAIL;
            step_ev = EV_ABORT;
        end else if (r_pos == '0) begin
            if (r_gap && r_byte == i_cfg.start_byte) begin
                n_pos = POS_W'(1);
                n_sum = SUM_INIT - {8'd0, r_byte};
                n_low = r_byte;
                if (r_link == LINK_NOSYNC) begin
                    n_link = LINK_ACQ;
                    n_acq  = '0;
                end
            end
        end else if (r_gap) begin
            n_pos   = '0;
            n_link  = LINK_FAIL;
            step_ev = EV_ABORT;
        end else if (r_pos == POS_W'(1)) begin
            if (r_byte == i_cfg.command_byte) begin
                ram_we = 1'b1;
                n_pos  = POS_W'(2);
                n_sum  = sum_sub;
                if (r_link == LINK_NOSYNC) begin
                    n_link = LINK_ACQ;
                    n_acq  = '0;
                end
            end
        end else begin
            // even byte waits in r_low, odd byte completes the pair
            if (r_pos[0]) begin
                ram_we = 1'b1;
            end else begin
                n_low = r_byte;
            end
            if (r_pos < SUM_LEN) begin
                n_sum = sum_sub;
            end
            if (r_pos == LAST_POS) begin
                n_pos = '0;
                if ({r_byte, r_low} != r_sum) begin
                    n_link  = LINK_FAIL;
                    step_ev = EV_BADSUM;
                end else begin
                    if (r_link == LINK_ACQ) begin
                        n_acq = acq_inc;
                        if (acq_inc >= i_cfg.acquire_frames) begin
                            n_link = LINK_READY;
                        end
                    end else begin
                        n_link = LINK_READY;
                    end
                    if (skip_inc <= i_cfg.frames_to_skip) begin
                        n_skip  = skip_inc;
                        step_ev = EV_HELD;
                    end else begin
                        n_skip  = '0;
                        step_ev = EV_PUB;
                    end
                end
            end else begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    ifd_ram #(
        .WIDTH(16),
        .DEPTH(FRAME_PAIRS)
    ) u_frame_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.step && ram_we),
        .i_waddr(r_pos[POS_W-1:1]),
        .i_wdata({r_byte, r_low}),
        .i_re   (i_cmd.read),
        .i_raddr(PAIR_AW'(r_chan) + PAIR_AW'(1)),
        .o_rdata(pair_data)
    );

    assign in_range  = (pair_data > i_cfg.pulse_low_limit) &&
                       (pair_data < i_cfg.pulse_high_limit);
    assign new_value = in_range ? pair_data : r_store[r_chan[CH_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_byte <= i_data_byte;
            r_err  <= i_rx_error;
            r_gap  <= i_gap_seen;
        end
        if (i_cmd.step) begin
            r_sum <= n_sum;
            r_low <= n_low;
        end
        if (i_cmd.step && step_ev != EV_PUB) begin
            r_out_link <= 2'(n_link);
            r_out_ev   <= 3'(step_ev);
            r_out_idx  <= '0;
            r_out_val  <= '0;
            r_out_last <= 1'b1;
        end else if (i_cmd.emit) begin
            r_out_link <= 2'(r_link);
            r_out_ev   <= 3'(EV_PUB);
            r_out_idx  <= r_chan;
            r_out_val  <= new_value;
            r_out_last <= (r_chan == LAST_CHAN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_link      <= LINK_NOSYNC;
            r_acq       <= '0;
            r_skip      <= '0;
            r_chan      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_store[i] <= CENTER;
            end
        end else begin
            if (i_cmd.step) begin
                r_pos  <= n_pos;
                r_link <= n_link;
                r_acq  <= n_acq;
                r_skip <= n_skip;
                r_chan <= '0;
            end else if (i_cmd.emit) begin
                r_chan <= r_chan + CHAN_W'(1);
                r_store[r_chan[CH_W-1:0]] <= new_value;
            end
            if ((i_cmd.step && step_ev != EV_PUB) || i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.step_pub  = (step_ev == EV_PUB);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_stat.last_chan = (r_chan == LAST_CHAN);

    assign o_out_valid     = r_out_valid;
    assign o_link_state    = r_out_link;
    assign o_frame_event   = r_out_ev;
    assign o_channel_index = r_out_idx;
    assign o_channel_value = r_out_val;
    assign o_last_result   = r_out_last;

endmodule

`default_nettype wire

FILE: sv/ibus_frame_decoder.sv
`default_nettype none

// serial radio-frame decoder: takes one received byte per transaction with its
// receive-error and line-gap flags, frames 32-byte frames (start byte after a gap,
// command byte, channel pairs, 16-bit checksum), tracks the link state and, on a
// published frame, returns one result per channel (new value if strictly between
// the pulse limits, else the stored value); every other byte returns one result.
// A byte is captured, then stepped once the output register is free; on a
// published frame each channel pair is then fetched from the frame store through
// its single read port, compared and written back. Results are held in an output
// register, so a stalled sink only delays further results. The user must write
// configuration over the APB port while no byte is in flight (not enforced).
module ibus_frame_decoder #(
    parameter int CHANNELS     = ifd_pkg::CHANNELS_DEF,
    parameter int CENTER_VALUE = ifd_pkg::CENTER_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    ifd_in_if.sink                              i_in,
    ifd_out_if.source                           o_out,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ifd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [ifd_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [ifd_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);

    import ifd_pkg::*;

    t_cfg     r_cfg;
    t_cmd     cmd;
    t_stat    stat;
    t_reg_idx reg_idx;
    logic     cfg_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte       <= 8'd32;
            r_cfg.command_byte     <= 8'd64;
            r_cfg.acquire_frames   <= 8'd5;
            r_cfg.frames_to_skip   <= 8'd0;
            r_cfg.pulse_low_limit  <= 16'd750;
            r_cfg.pulse_high_limit <= 16'd2250;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_START:   r_cfg.start_byte       <= pwdata[7:0];
                REG_COMMAND: r_cfg.command_byte     <= pwdata[7:0];
                REG_ACQUIRE: r_cfg.acquire_frames   <= pwdata[7:0];
                REG_SKIP:    r_cfg.frames_to_skip   <= pwdata[7:0];
                REG_LOW:     r_cfg.pulse_low_limit  <= pwdata[15:0];
                REG_HIGH:    r_cfg.pulse_high_limit <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_START:   prdata = {24'd0, r_cfg.start_byte};
            REG_COMMAND: prdata = {24'd0, r_cfg.command_byte};
            REG_ACQUIRE: prdata = {24'd0, r_cfg.acquire_frames};
            REG_SKIP:    prdata = {24'd0, r_cfg.frames_to_skip};
            REG_LOW:     prdata = {16'd0, r_cfg.pulse_low_limit};
            REG_HIGH:    prdata = {16'd0, r_cfg.pulse_high_limit};
            default:     prdata = '0;
        endcase
    end

    ifd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in.valid),
        .o_in_ready(i_in.ready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    ifd_datapath #(
        .CHANNELS    (CHANNELS),
        .CENTER_VALUE(CENTER_VALUE)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg          (r_cfg),
        .i_data_byte    (i_in.data_byte),
        .i_rx_error     (i_in.rx_error),
        .i_gap_seen     (i_in.gap_seen),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_link_state   (o_out.link_state),
        .o_frame_event  (o_out.frame_event),
        .o_channel_index(o_out.channel_index),
        .o_channel_value(o_out.channel_value),
        .o_last_result  (o_out.last_result)
    );

endmodule

`default_nettype wire
